// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Holds the list capacity, the field widths, the command codes and the
// control bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CMD_W    = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int CNT_W    = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   typedef struct packed {
      logic load;
      logic commit;
   } pls_ctrl_type;

endpackage

// ===== sv/pls_if.sv =====
// ----------------------------------------------------------------------------
// pls_if: request and response channels of the positional list store
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pls_req_if;
   logic                                valid;
   logic                                ready;
   logic [pls_pkg::CMD_W-1:0]           command;
   logic [pls_pkg::POS_W-1:0]           position;
   logic signed [pls_pkg::VALUE_W-1:0]  value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface pls_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ok;
   logic signed [pls_pkg::VALUE_W-1:0]  removed_value;
   logic [pls_pkg::CNT_W-1:0]           count;

   modport source (output valid, ok, removed_value, count, input ready);
   modport sink   (input valid, ok, removed_value, count, output ready);
endinterface

// ===== sv/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl: controller of the positional list store
// Takes one request, runs it through the datapath once any earlier response is
// taken, and keeps the response valid until the receiver takes it.
// ----------------------------------------------------------------------------
module pls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pls_pkg::pls_ctrl_type ctl
);
   import pls_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      commit;

   assign req_ready  = (state_ff == ST_IDLE);
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign ctl.load   = req_ready && req_valid;
   assign ctl.commit = commit;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== sv/pls_datapath.sv =====
// ----------------------------------------------------------------------------
// pls_datapath: list cells, entry count and response register
// Every cell takes its left or right neighbor at once, so an insert or a
// delete at any position moves all cells in a single commit.
// ----------------------------------------------------------------------------
module pls_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pls_pkg::pls_ctrl_type               ctl,
   input  logic [pls_pkg::CMD_W-1:0]           req_command,
   input  logic [pls_pkg::POS_W-1:0]           req_position,
   input  logic signed [pls_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_ok,
   output logic signed [pls_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [pls_pkg::CNT_W-1:0]           rsp_count
);
   import pls_pkg::*;

   logic [CMD_W-1:0]          cmd_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic signed [VALUE_W-1:0] cell_ff [CAPACITY];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      ok_ff;
   logic signed [VALUE_W-1:0] removed_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic [POS_W-1:0]          eff_pos;
   logic                      ins_ok;
   logic                      del_ok;
   logic signed [VALUE_W-1:0] read_value;

   always_comb begin
      eff_pos = (cmd_ff == CMD_APPEND) ? POS_W'(count_ff) : pos_ff;
      ins_ok  = 1'b0;
      del_ok  = 1'b0;
      unique case (cmd_ff)
         CMD_APPEND, CMD_INSERT: begin
            ins_ok = (count_ff < CNT_W'(CAPACITY)) && (eff_pos <= POS_W'(count_ff));
         end
         CMD_DELETE: begin
            del_ok = (pos_ff < POS_W'(count_ff));
         end
         default: begin
            ins_ok = 1'b0;
         end
      endcase
      read_value = cell_ff[pos_ff[IDX_W-1:0]];
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (del_ok) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (ins_ok) begin
               if (POS_W'(i) == eff_pos) begin
                  cell_ff[i] <= val_ff;
               end else if ((i > 0) && (POS_W'(i) > eff_pos)) begin
                  cell_ff[i] <= cell_ff[(i > 0) ? i - 1 : 0];
               end
            end else if (del_ok) begin
               if ((i < CAPACITY - 1) && (POS_W'(i) >= pos_ff)) begin
                  cell_ff[i] <= cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         ok_ff        <= ins_ok || del_ok;
         removed_ff   <= del_ok ? read_value : '0;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_ok            = ok_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

// ===== sv/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of up to 16 signed 32-bit values
// Each request carries a command (append, insert before a position, delete
// at a position), a position and a value. Each request yields exactly one
// response with ok, the removed value (zero unless a delete succeeded) and
// the entry count after the command. Bad positions, an add to a full list
// and the unused command code are rejected and leave the list unchanged.
// A request is taken when req_chan is valid and ready; it is registered,
// then run in the execute state, whose commit registers the response. A
// new request is taken only after the previous one has committed. The commit
// moves all list cells at once, so the position does not change the timing.
// The response sits in an output register: the next request is accepted
// while it waits, and only the execute cycle of that next request waits
// for the receiver. While rsp_chan is stalled the response holds steady.
// A synchronous reset empties the list and drops any pending response;
// the list contents themselves are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store (
   input  logic clock,
   input  logic reset,
   pls_req_if.sink   req_chan,
   pls_rsp_if.source rsp_chan
);
   import pls_pkg::*;

   pls_ctrl_type ctl;

   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   pls_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_command       (req_chan.command),
      .req_position      (req_chan.position),
      .req_value         (req_chan.value),
      .rsp_ok            (rsp_chan.ok),
      .rsp_removed_value (rsp_chan.removed_value),
      .rsp_count         (rsp_chan.count)
   );

endmodule
